[hw/rtl/klas_pkg.sv]
// Package for the keypad LED animation sequencer.
// Opcodes, animation kinds, control selects and LED mapping functions.
// No dependencies.
package klas_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_PLAY    = 3'd1,
    OP_TOUCH   = 3'd2,
    OP_WAKE    = 3'd3,
    OP_CONSUME = 3'd4,
    OP_CTRL    = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    A_NONE    = 3'd0,
    A_BLINK   = 3'd1,
    A_SUCCESS = 3'd2,
    A_FACTORY = 3'd3,
    A_MWAVE   = 3'd4,
    A_ERROR   = 3'd5,
    A_SNAKE   = 3'd6,
    A_IWAVE   = 3'd7
  } anim_t;

  typedef enum logic [1:0] {
    SEL_TSM     = 2'd0,
    SEL_RFID    = 2'd1,
    SEL_RELAY   = 2'd2,
    SEL_WIEGAND = 2'd3
  } ctrl_sel_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WINDOW = 3'd0,
    CFG_TSM    = 3'd1,
    CFG_RFID   = 3'd2,
    CFG_WIEG   = 3'd3,
    CFG_RELAY  = 3'd4
  } cfg_reg_t;

  localparam logic [11:0] SUCCESS_PAT = 12'h F6F;
  localparam logic [11:0] ERROR_PAT   = 12'h155;
  localparam logic [11:0] ALL_LEDS    = 12'hFFF;

  // Key mask to register bytes: {reg1 bits, reg2 bits}
  function automatic logic [15:0] led_map(input logic [11:0] m);
    logic [7:0] r1;
    logic [7:0] r2;
    r1 = '0;
    r2 = '0;
    r1[1] = m[0];
    r1[7] = m[1];
    r1[6] = m[2];
    r1[2] = m[3];
    r1[4] = m[4];
    r1[5] = m[5];
    r2[2] = m[6];
    r2[0] = m[7];
    r1[0] = m[8];
    r2[1] = m[9];
    r2[3] = m[10];
    r2[4] = m[11];
    return {r1, r2};
  endfunction

  function automatic logic [11:0] key_bit(input logic [3:0] key);
    logic [3:0] k;
    k = key - 4'd1;
    return (k < 4'd12) ? (12'd1 << k) : 12'd0;
  endfunction

  function automatic logic [3:0] ring_key(input logic [3:0] i);
    case (i)
      4'd0: return 4'd1;
      4'd1: return 4'd2;
      4'd2: return 4'd3;
      4'd3: return 4'd6;
      4'd4: return 4'd9;
      4'd5: return 4'd12;
      4'd6: return 4'd11;
      4'd7: return 4'd10;
      4'd8: return 4'd7;
      default: return 4'd4;
    endcase
  endfunction

  function automatic logic [3:0] snake_key(input logic [3:0] i);
    case (i)
      4'd0: return 4'd1;
      4'd1: return 4'd2;
      4'd2: return 4'd3;
      4'd3: return 4'd6;
      4'd4: return 4'd5;
      4'd5: return 4'd4;
      4'd6: return 4'd7;
      4'd7: return 4'd8;
      4'd8: return 4'd9;
      4'd9: return 4'd12;
      4'd10: return 4'd11;
      default: return 4'd10;
    endcase
  endfunction

  function automatic logic [11:0] row_mask(input logic [1:0] r);
    case (r)
      2'd0: return 12'h007;
      2'd1: return 12'h038;
      2'd2: return 12'h1C0;
      default: return 12'hE00;
    endcase
  endfunction

  function automatic logic [3:0] char_key(input logic [7:0] c);
    if (c >= 8'h31 && c <= 8'h39) return 4'(c - 8'h30);
    if (c == 8'h2A) return 4'd10;
    if (c == 8'h30) return 4'd11;
    if (c == 8'h23) return 4'd12;
    return 4'd0;
  endfunction

endpackage

[hw/rtl/klas_frame.sv]
// Animation frame selection for one tick step.
// Depends on klas_pkg. Pure combinational: gives LED mask and next step.
module klas_frame (
  input  klas_pkg::anim_t anim,
  input  logic [4:0]      step,
  input  logic [3:0]      blink_key,
  input  logic            flash_done,
  output logic            do_leds,
  output logic [11:0]     mask,
  output logic [11:0]     delay,
  output logic            set_next,
  output logic            next_is_now,
  output logic [4:0]      step_next,
  output logic            stop
);
  import klas_pkg::*;

  logic [4:0] s_mod10;
  logic [4:0] s_mod6;
  logic [4:0] sidx;
  logic [2:0] c6;

  always_comb begin
    s_mod10 = (step >= 5'd20) ? step - 5'd20 : (step >= 5'd10) ? step - 5'd10 : step;
    s_mod6  = (step >= 5'd12) ? step - 5'd12 : (step >= 5'd6) ? step - 5'd6 : step;
    sidx    = (step < 5'd12) ? step : 5'd23 - step;
    c6      = s_mod6[2:0];
  end

  always_comb begin
    do_leds = 1'b0;
    mask = '0;
    delay = '0;
    set_next = 1'b0;
    next_is_now = 1'b0;
    step_next = step;
    stop = 1'b0;
    case (anim)
      A_BLINK: begin
        if (step == 5'd0) begin
          do_leds = (blink_key >= 4'd1 && blink_key <= 4'd12);
          mask = key_bit(blink_key);
          delay = 12'd100;
          set_next = 1'b1;
          step_next = 5'd1;
        end else begin
          do_leds = 1'b1;
          stop = 1'b1;
        end
      end
      A_SUCCESS, A_ERROR: begin
        if (step == 5'd0) begin
          do_leds = 1'b1;
          delay = 12'd100;
          set_next = 1'b1;
          step_next = 5'd1;
        end else if (flash_done) begin
          do_leds = 1'b1;
          stop = 1'b1;
        end else begin
          do_leds = 1'b1;
          if (step == 5'd1) mask = (anim == A_SUCCESS) ? SUCCESS_PAT : ERROR_PAT;
          delay = 12'd300;
          set_next = 1'b1;
          step_next = (step == 5'd1) ? 5'd2 : 5'd1;
        end
      end
      A_FACTORY: begin
        if (step < 5'd30) begin
          do_leds = 1'b1;
          mask = key_bit(ring_key(s_mod10[3:0]));
          delay = 12'd40;
          set_next = 1'b1;
          step_next = step + 5'd1;
        end else if (step == 5'd30) begin
          do_leds = 1'b1;
          delay = 12'd50;
          set_next = 1'b1;
          step_next = 5'd31;
        end else begin
          stop = 1'b1;
        end
      end
      A_MWAVE: begin
        if (step < 5'd4) begin
          do_leds = 1'b1;
          mask = row_mask(step[1:0]);
          delay = 12'd70;
          set_next = 1'b1;
          step_next = step + 5'd1;
        end else begin
          do_leds = 1'b1;
          stop = 1'b1;
        end
      end
      A_SNAKE: begin
        if (step < 5'd24) begin
          do_leds = 1'b1;
          mask = key_bit(snake_key(sidx[3:0]));
          delay = 12'd80;
          set_next = 1'b1;
          step_next = step + 5'd1;
        end else if (step == 5'd24) begin
          do_leds = 1'b1;
          delay = 12'd3000;
          set_next = 1'b1;
          step_next = 5'd25;
        end else begin
          next_is_now = 1'b1;
          step_next = 5'd0;
        end
      end
      A_IWAVE: begin
        if (step < 5'd18) begin
          do_leds = 1'b1;
          mask = row_mask((c6 < 3'd4) ? c6[1:0] : 2'(3'd6 - c6));
          delay = 12'd150;
          set_next = 1'b1;
          step_next = step + 5'd1;
        end else if (step == 5'd18) begin
          do_leds = 1'b1;
          delay = 12'd3000;
          set_next = 1'b1;
          step_next = 5'd19;
        end else begin
          next_is_now = 1'b1;
          step_next = 5'd0;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/keypad_led_animation_sequencer_unit.sv]
// Keypad LED animation sequencer, top level.
// A result word is registered and appears the cycle after its input word is accepted.
// Throughput: one word per cycle; input ready only drops while a result
// waits and the result side is stalled. All state updates in that one pass.
// Synchronous reset rst loads register defaults; clears all but latched/wakeup_touch.
module keypad_led_animation_sequencer_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [2:0]  anim_kind,
  input  logic [15:0] anim_arg,
  input  logic [11:0] touch_mask,
  input  logic [1:0]  control_select,
  input  logic        control_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  reg1_value,
  output logic [7:0]  reg2_value,
  output logic        latched,
  output logic        keypad_active,
  output logic        wakeup_touch,
  output logic        blocking_anim
);
  import klas_pkg::*;

  typedef logic [TIME_BITS-1:0] tm_t;

  logic [15:0] active_window_ms;
  logic [2:0]  tsm_reset_bit, rfid_reset_bit, wiegand_enable_bit, relay_bit;

  tm_t clock_ms, next_step_time, anim_end_time, window_end_time;
  tm_t blink_restore_time, last_touch_change;
  logic [7:0] out_reg1, out_reg2;
  anim_t anim_running;
  logic [4:0] anim_step_count;
  logic [3:0] blink_key;
  logic forced_on, wakeup_pending;
  logic [11:0] last_touch;

  tm_t clock_ms_next, next_step_time_next, anim_end_time_next, window_end_time_next;
  tm_t blink_restore_time_next, last_touch_change_next;
  logic [7:0] out_reg1_next, out_reg2_next;
  anim_t anim_running_next;
  logic [4:0] anim_step_count_next;
  logic [3:0] blink_key_next;
  logic forced_on_next, wakeup_pending_next;
  logic [11:0] last_touch_next;
  logic latch_v, wake_v;

  logic accept;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_window_ms   <= 16'd20000;
      tsm_reset_bit      <= 3'd3;
      rfid_reset_bit     <= 3'd5;
      wiegand_enable_bit <= 3'd6;
      relay_bit          <= 3'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW: active_window_ms <= cfg_data;
        CFG_TSM:    tsm_reset_bit <= cfg_data[2:0];
        CFG_RFID:   rfid_reset_bit <= cfg_data[2:0];
        CFG_WIEG:   wiegand_enable_bit <= cfg_data[2:0];
        CFG_RELAY:  relay_bit <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Frame logic works on the ticked clock and the state before the step.
  tm_t now_tick;
  assign now_tick = clock_ms + tm_t'(1);

  logic f_leds, f_set, f_now, f_stop;
  logic [11:0] f_mask, f_delay;
  logic [4:0] f_step;

  klas_frame u_frame (
    .anim(anim_running), .step(anim_step_count), .blink_key(blink_key),
    .flash_done(now_tick >= anim_end_time),
    .do_leds(f_leds), .mask(f_mask), .delay(f_delay), .set_next(f_set),
    .next_is_now(f_now), .step_next(f_step), .stop(f_stop)
  );

  // Control bits kept across an LED rewrite
  logic [7:0] keep1, keep2;
  always_comb begin
    keep1 = 8'd1 << tsm_reset_bit;
    keep2 = (8'd1 << rfid_reset_bit) | (8'd1 << wiegand_enable_bit) | (8'd1 << relay_bit);
  end

  logic [11:0] led_req;
  logic        led_do;
  logic        led_pre;
  logic [15:0] mapped;
  logic [15:0] pre_mapped;
  logic        blocking_cur;
  logic        in_win;
  logic        touch_fill;
  logic [7:0]  cmask;
  logic [2:0]  cpos;

  assign blocking_cur = anim_running == A_SUCCESS || anim_running == A_ERROR ||
                        anim_running == A_FACTORY;

  always_comb begin
    clock_ms_next = clock_ms;
    next_step_time_next = next_step_time;
    anim_end_time_next = anim_end_time;
    window_end_time_next = window_end_time;
    blink_restore_time_next = blink_restore_time;
    last_touch_change_next = last_touch_change;
    out_reg1_next = out_reg1;
    out_reg2_next = out_reg2;
    anim_running_next = anim_running;
    anim_step_count_next = anim_step_count;
    blink_key_next = blink_key;
    forced_on_next = forced_on;
    wakeup_pending_next = wakeup_pending;
    last_touch_next = last_touch;
    led_do = 1'b0;
    led_pre = 1'b0;
    led_req = '0;
    wake_v = 1'b0;
    latch_v = 1'b0;
    in_win = clock_ms < window_end_time;
    touch_fill = 1'b0;
    cpos = '0;
    cmask = '0;
    case (opcode)
      OP_TICK: begin
        clock_ms_next = now_tick;
        // the last LED write in the tick wins; the frame step comes last
        if (blink_restore_time != '0 && now_tick >= blink_restore_time) begin
          blink_restore_time_next = '0;
          if (forced_on && anim_running == A_NONE) begin
            led_do = 1'b1;
            led_pre = 1'b1;
            led_req = ALL_LEDS;
          end
        end
        if (forced_on) begin
          if (now_tick >= window_end_time) begin
            forced_on_next = 1'b0;
            blink_restore_time_next = '0;
            if (anim_running == A_NONE) begin
              led_do = 1'b1;
              led_req = '0;
            end
          end else if (anim_running == A_NONE && blink_restore_time_next == '0) begin
            led_do = 1'b1;
            led_req = ALL_LEDS;
          end
        end
        if (anim_running != A_NONE && now_tick >= next_step_time) begin
          if (f_leds) begin
            led_do = 1'b1;
            led_req = f_mask;
          end
          if (f_set) next_step_time_next = now_tick + tm_t'(f_delay);
          if (f_now) next_step_time_next = now_tick;
          anim_step_count_next = f_step;
          if (f_stop) anim_running_next = A_NONE;
        end
      end
      OP_PLAY: begin
        anim_running_next = anim_t'(anim_kind);
        anim_step_count_next = '0;
        next_step_time_next = clock_ms;
        blink_restore_time_next = '0;
        if (anim_t'(anim_kind) == A_BLINK) blink_key_next = char_key(anim_arg[7:0]);
        else if (anim_t'(anim_kind) == A_SUCCESS || anim_t'(anim_kind) == A_ERROR)
          anim_end_time_next = clock_ms + tm_t'(anim_arg);
      end
      OP_TOUCH: begin
        if (!blocking_cur) begin
          if (touch_mask != last_touch) begin
            if (touch_mask != '0) begin
              led_do = 1'b1;
              if (!in_win) begin
                wakeup_pending_next = 1'b1;
                led_req = ALL_LEDS;
              end else begin
                led_req = ~touch_mask;
                blink_restore_time_next = clock_ms + tm_t'(220);
              end
              window_end_time_next = clock_ms + tm_t'(active_window_ms);
              forced_on_next = 1'b1;
              anim_running_next = A_NONE;
            end
            last_touch_next = touch_mask;
            last_touch_change_next = clock_ms;
          end else if (last_touch != '0 && (clock_ms - last_touch_change) > tm_t'(200)) begin
            last_touch_next = '0;
            if (in_win && blink_restore_time == '0 && anim_running == A_NONE)
              touch_fill = 1'b1;
          end
          if (touch_mask == '0 && in_win && blink_restore_time_next == '0 &&
              anim_running_next == A_NONE)
            touch_fill = 1'b1;
          if (touch_fill) begin
            led_do = 1'b1;
            led_req = ALL_LEDS;
          end
        end
      end
      OP_WAKE: begin
        window_end_time_next = clock_ms + tm_t'(active_window_ms);
        forced_on_next = 1'b1;
        if (!blocking_cur) begin
          anim_running_next = A_NONE;
          led_do = 1'b1;
          led_req = ALL_LEDS;
        end
      end
      OP_CONSUME: begin
        wake_v = wakeup_pending;
        wakeup_pending_next = 1'b0;
      end
      OP_CTRL: begin
        case (ctrl_sel_t'(control_select))
          SEL_TSM:   cpos = tsm_reset_bit;
          SEL_RFID:  cpos = rfid_reset_bit;
          SEL_RELAY: cpos = relay_bit;
          default:   cpos = wiegand_enable_bit;
        endcase
        cmask = 8'd1 << cpos;
        latch_v = 1'b1;
        if (ctrl_sel_t'(control_select) == SEL_TSM)
          out_reg1_next = control_level ? (out_reg1 | cmask) : (out_reg1 & ~cmask);
        else
          out_reg2_next = control_level ? (out_reg2 | cmask) : (out_reg2 & ~cmask);
      end
      default: ;
    endcase
    mapped = led_map(led_req);
    // an all-on restore earlier in the same tick leaves its bits in the kept positions
    pre_mapped = led_pre ? led_map(ALL_LEDS) : '0;
    if (led_do) begin
      latch_v = 1'b1;
      out_reg1_next = ((out_reg1 | pre_mapped[15:8]) & keep1) | mapped[15:8];
      out_reg2_next = ((out_reg2 | pre_mapped[7:0]) & keep2) | mapped[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms <= '0;
      next_step_time <= '0;
      anim_end_time <= '0;
      window_end_time <= '0;
      blink_restore_time <= '0;
      last_touch_change <= '0;
      out_reg1 <= '0;
      out_reg2 <= '0;
      anim_running <= A_NONE;
      anim_step_count <= '0;
      blink_key <= '0;
      forced_on <= 1'b0;
      wakeup_pending <= 1'b0;
      last_touch <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        clock_ms <= clock_ms_next;
        next_step_time <= next_step_time_next;
        anim_end_time <= anim_end_time_next;
        window_end_time <= window_end_time_next;
        blink_restore_time <= blink_restore_time_next;
        last_touch_change <= last_touch_change_next;
        out_reg1 <= out_reg1_next;
        out_reg2 <= out_reg2_next;
        anim_running <= anim_running_next;
        anim_step_count <= anim_step_count_next;
        blink_key <= blink_key_next;
        forced_on <= forced_on_next;
        wakeup_pending <= wakeup_pending_next;
        last_touch <= last_touch_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      latched <= latch_v;
      wakeup_touch <= wake_v;
    end
  end

  assign reg1_value = out_reg1;
  assign reg2_value = out_reg2;
  assign keypad_active = clock_ms < window_end_time;
  assign blocking_anim = anim_running == A_SUCCESS || anim_running == A_ERROR ||
                         anim_running == A_FACTORY;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(reg1_value) && $stable(reg2_value))
    else $error("result changed while stalled");

  a_clock: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(clock_ms))
    else $error("clock moved without a word");

  a_wake: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == OP_CONSUME |=> !wakeup_pending)
    else $error("wakeup not consumed");

endmodule

[dv/klas_checker.sv]
// Checker for the keypad LED animation sequencer: watches the config, input and
// result channels, predicts every result word and compares it field by field.
// Depends on klas_pkg for opcode, animation and control-select codes.
`timescale 1ns / 1ps
module klas_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [2:0]  anim_kind,
  input  logic [15:0] anim_arg,
  input  logic [11:0] touch_mask,
  input  logic [1:0]  control_select,
  input  logic        control_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  reg1_value,
  input  logic [7:0]  reg2_value,
  input  logic        latched,
  input  logic        keypad_active,
  input  logic        wakeup_touch,
  input  logic        blocking_anim,
  output int          fail_count,
  output int          pending
);
  import klas_pkg::*;

  typedef struct packed {
    logic [7:0] r1;
    logic [7:0] r2;
    logic       lat;
    logic       act;
    logic       wake;
    logic       blk;
  } led_word_t;

  led_word_t expected_words[$];

  logic [15:0] win_ms;
  logic [2:0]  tsm_pos, rfid_pos, wieg_pos, relay_pos;
  logic [31:0] now_ms, next_step, anim_end, win_end, restore_at, touch_since;
  logic [7:0]  reg1, reg2;
  anim_t       anim;
  logic [4:0]  step;
  logic [3:0]  blink;
  logic        forced, wake_pend, lat_flag;
  logic [11:0] last_mask;

  function automatic logic [3:0] key_of_char(input logic [7:0] c);
    if (c >= "1" && c <= "9") return 4'(c - "0");
    if (c == "*") return 4'd10;
    if (c == "0") return 4'd11;
    if (c == "#") return 4'd12;
    return 4'd0;
  endfunction

  function automatic logic [11:0] one_key(input logic [3:0] k);
    return 12'd1 << ((k - 4'd1) & 4'hF);
  endfunction

  function automatic logic [11:0] row_bits(input int r);
    case (r)
      0: return 12'h007;
      1: return 12'h038;
      2: return 12'h1C0;
      default: return 12'hE00;
    endcase
  endfunction

  function automatic logic [3:0] ring_at(input int i);
    logic [3:0] t[10];
    t = '{4'd1, 4'd2, 4'd3, 4'd6, 4'd9, 4'd12, 4'd11, 4'd10, 4'd7, 4'd4};
    return t[i];
  endfunction

  function automatic logic [3:0] snake_at(input int i);
    logic [3:0] t[12];
    t = '{4'd1, 4'd2, 4'd3, 4'd6, 4'd5, 4'd4, 4'd7, 4'd8, 4'd9, 4'd12, 4'd11, 4'd10};
    return t[i];
  endfunction

  function automatic logic is_blocking();
    return anim == A_SUCCESS || anim == A_ERROR || anim == A_FACTORY;
  endfunction

  function automatic void show_leds(input logic [11:0] m);
    logic [7:0] keep2, r1, r2;
    int pos1[12];
    int on2[12];
    pos1 = '{1, 7, 6, 2, 4, 5, 2, 0, 0, 1, 3, 4};
    on2  = '{0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 1, 1};
    keep2 = (8'd1 << rfid_pos) | (8'd1 << wieg_pos) | (8'd1 << relay_pos);
    r1 = reg1 & (8'd1 << tsm_pos);
    r2 = reg2 & keep2;
    for (int i = 0; i < 12; i++)
      if (m[i]) begin
        if (on2[i] != 0) r2[pos1[i]] = 1'b1;
        else r1[pos1[i]] = 1'b1;
      end
    reg1 = r1;
    reg2 = r2;
    lat_flag = 1'b1;
  endfunction

  function automatic void flash_step(input logic [11:0] pat);
    if (step == 5'd0) begin
      show_leds(12'h000);
      next_step = now_ms + 32'd100;
      step = 5'd1;
    end else if (now_ms >= anim_end) begin
      anim = A_NONE;
      show_leds(12'h000);
    end else begin
      show_leds(step == 5'd1 ? pat : 12'h000);
      next_step = now_ms + 32'd300;
      step = (step == 5'd1) ? 5'd2 : 5'd1;
    end
  endfunction

  function automatic void advance_ms();
    int s;
    now_ms = now_ms + 32'd1;
    if (restore_at != 0 && now_ms >= restore_at) begin
      restore_at = '0;
      if (forced && anim == A_NONE) show_leds(ALL_LEDS);
    end
    if (forced) begin
      if (now_ms >= win_end) begin
        forced = 1'b0;
        restore_at = '0;
        if (anim == A_NONE) show_leds(12'h000);
      end else if (anim == A_NONE && restore_at == 0) begin
        show_leds(ALL_LEDS);
      end
    end
    if (anim == A_NONE || now_ms < next_step) return;
    s = int'(step);
    case (anim)
      A_BLINK: begin
        if (s == 0) begin
          if (blink >= 1 && blink <= 12) show_leds(one_key(blink));
          next_step = now_ms + 32'd100;
          step = 5'd1;
        end else begin
          show_leds(12'h000);
          anim = A_NONE;
        end
      end
      A_SUCCESS: flash_step(SUCCESS_PAT);
      A_ERROR:   flash_step(ERROR_PAT);
      A_FACTORY: begin
        if (s < 30) begin
          show_leds(one_key(ring_at(s % 10)));
          next_step = now_ms + 32'd40;
          step = 5'(s + 1);
        end else if (s == 30) begin
          show_leds(12'h000);
          next_step = now_ms + 32'd50;
          step = 5'd31;
        end else anim = A_NONE;
      end
      A_MWAVE: begin
        if (s < 4) begin
          show_leds(row_bits(s));
          next_step = now_ms + 32'd70;
          step = 5'(s + 1);
        end else begin
          show_leds(12'h000);
          anim = A_NONE;
        end
      end
      A_SNAKE: begin
        if (s < 24) begin
          show_leds(one_key(snake_at(s < 12 ? s : 23 - s)));
          next_step = now_ms + 32'd80;
          step = 5'(s + 1);
        end else if (s == 24) begin
          show_leds(12'h000);
          next_step = now_ms + 32'd3000;
          step = 5'd25;
        end else begin
          step = 5'd0;
          next_step = now_ms;
        end
      end
      default: begin
        if (s < 18) begin
          show_leds(row_bits((s % 6) < 4 ? (s % 6) : 6 - (s % 6)));
          next_step = now_ms + 32'd150;
          step = 5'(s + 1);
        end else if (s == 18) begin
          show_leds(12'h000);
          next_step = now_ms + 32'd3000;
          step = 5'd19;
        end else begin
          step = 5'd0;
          next_step = now_ms;
        end
      end
    endcase
  endfunction

  function automatic void take_touch(input logic [11:0] m);
    logic in_win;
    if (is_blocking()) return;
    in_win = now_ms < win_end;
    if (m != last_mask) begin
      if (m != 0) begin
        if (!in_win) begin
          wake_pend = 1'b1;
          show_leds(ALL_LEDS);
        end else begin
          show_leds(~m);
          restore_at = now_ms + 32'd220;
        end
        win_end = now_ms + 32'(win_ms);
        forced = 1'b1;
        anim = A_NONE;
      end
      last_mask = m;
      touch_since = now_ms;
    end else if (last_mask != 0 && (now_ms - touch_since) > 32'd200) begin
      // touch held too long: treat as stuck and release it
      last_mask = '0;
      if (now_ms < win_end && restore_at == 0 && anim == A_NONE) show_leds(ALL_LEDS);
    end
    if (m == 0 && in_win && restore_at == 0 && anim == A_NONE) show_leds(ALL_LEDS);
  endfunction

  function automatic led_word_t predict_word(input logic [2:0] op, input logic [2:0] kind,
                                             input logic [15:0] arg, input logic [11:0] m,
                                             input logic [1:0] sel, input logic lvl);
    led_word_t w;
    logic [2:0] pos;
    logic wk;
    wk = 1'b0;
    lat_flag = 1'b0;
    pos = '0;
    case (op)
      OP_TICK: advance_ms();
      OP_PLAY: begin
        anim = anim_t'(kind);
        step = 5'd0;
        next_step = now_ms;
        restore_at = '0;
        if (kind == A_BLINK) blink = key_of_char(arg[7:0]);
        else if (kind == A_SUCCESS || kind == A_ERROR) anim_end = now_ms + 32'(arg);
      end
      OP_TOUCH: take_touch(m);
      OP_WAKE: begin
        win_end = now_ms + 32'(win_ms);
        forced = 1'b1;
        if (!is_blocking()) begin
          anim = A_NONE;
          show_leds(ALL_LEDS);
        end
      end
      OP_CONSUME: begin
        wk = wake_pend;
        wake_pend = 1'b0;
      end
      OP_CTRL: begin
        case (sel)
          SEL_TSM:   pos = tsm_pos;
          SEL_RFID:  pos = rfid_pos;
          SEL_RELAY: pos = relay_pos;
          default:   pos = wieg_pos;
        endcase
        if (sel == SEL_TSM) reg1[pos] = lvl;
        else reg2[pos] = lvl;
        lat_flag = 1'b1;
      end
      default: ;
    endcase
    w.r1 = reg1;
    w.r2 = reg2;
    w.lat = lat_flag;
    w.act = now_ms < win_end;
    w.wake = wk;
    w.blk = is_blocking();
    return w;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    led_word_t e;
    led_word_t a;
    if (rst) begin
      win_ms = 16'd20000;
      tsm_pos = 3'd3; rfid_pos = 3'd5; wieg_pos = 3'd6; relay_pos = 3'd7;
      now_ms = '0; next_step = '0; anim_end = '0; win_end = '0;
      restore_at = '0; touch_since = '0;
      reg1 = '0; reg2 = '0; anim = A_NONE; step = '0; blink = '0;
      forced = 1'b0; wake_pend = 1'b0; lat_flag = 1'b0; last_mask = '0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          CFG_WINDOW: win_ms = cfg_data;
          CFG_TSM:    tsm_pos = cfg_data[2:0];
          CFG_RFID:   rfid_pos = cfg_data[2:0];
          CFG_WIEG:   wieg_pos = cfg_data[2:0];
          CFG_RELAY:  relay_pos = cfg_data[2:0];
          default: ;
        endcase
      if (out_valid && out_ready) begin
        a = '{reg1_value, reg2_value, latched, keypad_active, wakeup_touch, blocking_anim};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", a);
        end else begin
          e = expected_words.pop_front();
          if (a !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp r1=%h r2=%h lat=%b act=%b wake=%b blk=%b",
                        " / got r1=%h r2=%h lat=%b act=%b wake=%b blk=%b"},
                       e.r1, e.r2, e.lat, e.act, e.wake, e.blk,
                       a.r1, a.r2, a.lat, a.act, a.wake, a.blk);
          end
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(predict_word(opcode, anim_kind, anim_arg, touch_mask,
                                              control_select, control_level));
    end
  end
endmodule

[dv/keypad_led_animation_sequencer_unit_test.sv]
// Testbench top for the keypad LED animation sequencer: drives config writes and
// command words through four idle/stall phases; klas_checker does the prediction.
// Depends on klas_pkg, klas_checker and the block itself.
`timescale 1ns / 1ps
module keypad_led_animation_sequencer_unit_test;
  import klas_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic [2:0] opcode = 0, anim_kind = 0;
  logic [15:0] anim_arg = 0;
  logic [11:0] touch_mask = 0;
  logic [1:0] control_select = 0;
  logic control_level = 0;
  logic out_valid, out_ready = 0;
  logic [7:0] reg1_value, reg2_value;
  logic latched, keypad_active, wakeup_touch, blocking_anim;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0, quiet = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  keypad_led_animation_sequencer_unit i_dut (.*);

  klas_checker i_checker (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
        (out_valid && out_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("keypad_led_animation_sequencer_unit test failed");
      $finish;
    end
  end

  // valid stays up between back-to-back words; callers drop it before waiting
  task automatic send_word(input opcode_t op, input anim_t kind, input logic [15:0] arg,
                           input logic [11:0] m, input ctrl_sel_t sel, input logic lvl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    opcode <= op; anim_kind <= kind; anim_arg <= arg;
    touch_mask <= m; control_select <= sel; control_level <= lvl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic ticks(input int n);
    for (int i = 0; i < n; i++) send_word(OP_TICK, A_NONE, 0, 0, SEL_TSM, 0);
  endtask

  // mostly ticks so the animations actually run; others mixed in
  task automatic random_word();
    int r;
    r = $urandom_range(99);
    if (r < 55) ticks(1 + $urandom_range(8));
    else if (r < 63)
      send_word(OP_PLAY, anim_t'($urandom_range(7)),
                $urandom_range(3) == 0 ? 16'($urandom) :
                ($urandom_range(1) ? 16'($urandom_range(2000)) : 16'("0" + $urandom_range(9))),
                0, SEL_TSM, 0);
    else if (r < 80)
      send_word(OP_TOUCH, A_NONE, 0,
                $urandom_range(2) == 0 ? 12'h000 : 12'($urandom), SEL_TSM, 0);
    else if (r < 85) send_word(OP_WAKE, A_NONE, 0, 0, SEL_TSM, 0);
    else if (r < 90) send_word(OP_CONSUME, A_NONE, 0, 0, SEL_TSM, 0);
    else if (r < 97)
      send_word(OP_CTRL, A_NONE, 0, 0, ctrl_sel_t'($urandom_range(3)), 1'($urandom));
    else send_word(opcode_t'(3'd6 + $urandom_range(1)), anim_t'($urandom_range(7)),
                   16'($urandom), 12'($urandom), ctrl_sel_t'($urandom_range(3)), 1'($urandom));
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    phase_idle = '{0, 56, 0, 19};
    phase_stall = '{0, 0, 56, 19};
    repeat (2) @(negedge clk);
    rst <= 0;
    // directed: every opcode, extremes, control bits, blocking touch, unknown ops
    send_word(OP_CTRL, A_NONE, 0, 0, SEL_TSM, 1);
    send_word(OP_CTRL, A_NONE, 0, 0, SEL_RFID, 1);
    send_word(OP_CTRL, A_NONE, 0, 0, SEL_RELAY, 1);
    send_word(OP_CTRL, A_NONE, 0, 0, SEL_WIEGAND, 1);
    send_word(OP_TOUCH, A_NONE, 0, 12'hFFF, SEL_TSM, 0);
    send_word(OP_CONSUME, A_NONE, 0, 0, SEL_TSM, 0);
    send_word(OP_TOUCH, A_NONE, 0, 12'h001, SEL_TSM, 0);
    ticks(3);
    send_word(OP_PLAY, A_BLINK, 16'h0023, 0, SEL_TSM, 0);
    ticks(2);
    send_word(OP_PLAY, A_SUCCESS, 16'hFFFF, 0, SEL_TSM, 0);
    send_word(OP_TOUCH, A_NONE, 0, 12'h800, SEL_TSM, 0);
    send_word(OP_WAKE, A_NONE, 0, 0, SEL_TSM, 0);
    send_word(OP_PLAY, A_ERROR, 16'd0, 0, SEL_TSM, 0);
    ticks(2);
    send_word(OP_PLAY, A_FACTORY, 0, 0, SEL_TSM, 0);
    send_word(opcode_t'(3'd6), A_IWAVE, 16'hFFFF, 12'hFFF, SEL_WIEGAND, 1);
    send_word(opcode_t'(3'd7), A_NONE, 0, 0, SEL_TSM, 0);
    send_word(OP_PLAY, A_MWAVE, 0, 0, SEL_TSM, 0);
    send_word(OP_PLAY, A_SNAKE, 0, 0, SEL_TSM, 0);
    send_word(OP_PLAY, A_IWAVE, 0, 0, SEL_TSM, 0);
    send_word(OP_PLAY, A_NONE, 0, 0, SEL_TSM, 0);
    send_word(OP_CTRL, A_NONE, 0, 0, SEL_RELAY, 0);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      case (p)
        0: begin write_reg(CFG_WINDOW, 16'd0); write_reg(CFG_TSM, 16'd0);
                 write_reg(CFG_RFID, 16'd0); write_reg(CFG_WIEG, 16'd0);
                 write_reg(CFG_RELAY, 16'd0); end
        1: begin write_reg(CFG_WINDOW, 16'hFFFF); write_reg(CFG_TSM, 16'd7);
                 write_reg(CFG_RFID, 16'd7); write_reg(CFG_WIEG, 16'd7);
                 write_reg(CFG_RELAY, 16'd7); end
        2: begin write_reg(CFG_WINDOW, 16'd300); write_reg(CFG_TSM, 16'd1);
                 write_reg(CFG_RFID, 16'd2); write_reg(CFG_WIEG, 16'd4);
                 write_reg(CFG_RELAY, 16'd3); end
        default: begin write_reg(CFG_WINDOW, 16'd20000); write_reg(CFG_TSM, 16'd3);
                       write_reg(CFG_RFID, 16'd5); write_reg(CFG_WIEG, 16'd6);
                       write_reg(CFG_RELAY, 16'd7); end
      endcase
      for (int i = 0; i < 68; i++) random_word();
      in_valid <= 0;
      while (pending != 0) @(negedge clk);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("keypad_led_animation_sequencer_unit test passed");
    else
      $display("keypad_led_animation_sequencer_unit test failed");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/klas_pkg.sv
hw/rtl/klas_frame.sv
hw/rtl/keypad_led_animation_sequencer_unit.sv
dv/klas_checker.sv
dv/keypad_led_animation_sequencer_unit_test.sv
